// ===== rtl/matrix3x3_inverse_core_defines.svh =====
// Assertion macros shared by the checker of the 3x3 matrix inverse core.
// Depends on nothing; the including scope must provide clk and rst_n.
`ifndef MATRIX3X3_INVERSE_CORE_DEFINES_SVH
`define MATRIX3X3_INVERSE_CORE_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define M3INV_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("m3inv check failed");

// Implication with a fixed delay in cycles.
`define M3INV_ASSERT_DELAY(lbl, ante, dly, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##(dly) (cons)) \
        else $error("m3inv check failed");

`endif

// ===== rtl/m3inv_pkg.sv =====
// Package for the 3x3 matrix inverse core: widths, word types, register codes.
// Used by the core and its checker; depends on nothing.
package m3inv_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 16;
    localparam int THR_W      = 31;
    localparam int ADDR_W     = 3;
    localparam int LATENCY    = DATA_WIDTH + 10;

    localparam logic [0:0]       REG_THRESHOLD = 1'b0;
    localparam logic [THR_W-1:0] THR_RESET     = THR_W'(1);

    typedef logic signed [DATA_WIDTH-1:0] elem_t;

    typedef struct packed {
        elem_t a00;
        elem_t a01;
        elem_t a02;
        elem_t a10;
        elem_t a11;
        elem_t a12;
        elem_t a20;
        elem_t a21;
        elem_t a22;
    } in_word_t;

    typedef struct packed {
        elem_t b00;
        elem_t b01;
        elem_t b02;
        elem_t b10;
        elem_t b11;
        elem_t b12;
        elem_t b20;
        elem_t b21;
        elem_t b22;
        elem_t det_value;
        logic  singular;
        logic  overflowed;
    } out_word_t;

endpackage

// ===== rtl/matrix3x3_inverse_core.sv =====
// 3x3 matrix inverse by the adjugate: a fully pipelined core that takes one matrix
// word per clock (busy never rises) and delivers its result word, marked by done for
// one cycle. The pipeline is built of seven stages of cofactor and determinant
// arithmetic, a one-bit-per-stage divider (DATA_WIDTH + 2 stages) and the saturating
// output register. The receiver cannot stall, so nothing is held back. Write the
// singular threshold only while the pipeline is empty.
module matrix3x3_inverse_core #(
    parameter int FRAC_BITS = m3inv_pkg::FRAC_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  m3inv_pkg::in_word_t           matrix,
    output m3inv_pkg::out_word_t          result,
    output logic                          done,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [m3inv_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    localparam int W    = m3inv_pkg::DATA_WIDTH;
    localparam int THW  = m3inv_pkg::THR_W;
    localparam int CW   = 2 * W + 1;
    localparam int CMW  = 2 * W;
    localparam int DTW  = 3 * W + 1;
    localparam int MAGW = 3 * W;
    localparam int SHW  = THW + 2 * FRAC_BITS;
    localparam int SCW  = (MAGW > SHW) ? MAGW : SHW;
    localparam int DRW  = MAGW + 1 - 2 * FRAC_BITS;
    localparam int DCW  = (DRW > W + 1) ? DRW : W + 1;
    localparam int NW   = ((2 * W + 2 * FRAC_BITS + 1 > MAGW) ?
                           2 * W + 2 * FRAC_BITS + 1 : MAGW) + 1;
    localparam int DVW  = MAGW + 1;
    localparam int QW   = W + 1;
    localparam int TAG_W = W + 11;
    localparam logic signed [W-1:0] ONE_VAL = (FRAC_BITS <= W - 2) ?
        (W'(1) << FRAC_BITS) : {1'b0, {(W-1){1'b1}}};
    localparam bit ONE_OVF = (FRAC_BITS > W - 2);

    // Configuration register
    logic [THW-1:0] thr_reg;
    logic           cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= m3inv_pkg::THR_RESET;
        end
        else if (cfg_wr && paddr[m3inv_pkg::ADDR_W-1:2] == m3inv_pkg::REG_THRESHOLD)
        begin
            thr_reg <= pwdata[THW-1:0];
        end
    end

    always_comb
    begin
        unique case (paddr[m3inv_pkg::ADDR_W-1:2])
            m3inv_pkg::REG_THRESHOLD: prdata = 32'(thr_reg);
            default:                  prdata = '0;
        endcase
    end

    assign busy = 1'b0;

    logic accept;
    assign accept = start & ~busy;

    logic [6:0] vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[5:0], accept};
        end
    end

    // Stage 0: capture the word
    logic signed [W-1:0] a_in  [9];
    logic signed [W-1:0] a_reg [9];

    assign a_in[0] = matrix.a00;
    assign a_in[1] = matrix.a01;
    assign a_in[2] = matrix.a02;
    assign a_in[3] = matrix.a10;
    assign a_in[4] = matrix.a11;
    assign a_in[5] = matrix.a12;
    assign a_in[6] = matrix.a20;
    assign a_in[7] = matrix.a21;
    assign a_in[8] = matrix.a22;

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 9; k++)
        begin
            a_reg[k] <= a_in[k];
        end
    end

    // Stage 1: minor products; stage 2: cofactors
    logic signed [2*W-1:0] p_reg   [9];
    logic signed [2*W-1:0] q_reg   [9];
    logic signed [CW-1:0]  cof_reg [9];
    logic signed [W-1:0]   a0_s1_reg [3];
    logic signed [W-1:0]   a0_s2_reg [3];

    for (genvar i = 0; i < 3; i++)
    begin : g_row
        for (genvar j = 0; j < 3; j++)
        begin : g_col
            localparam int R1 = (i + 1) % 3;
            localparam int R2 = (i + 2) % 3;
            localparam int C1 = (j + 1) % 3;
            localparam int C2 = (j + 2) % 3;
            always_ff @(posedge clk)
            begin
                p_reg[i*3+j]   <= a_reg[R1*3+C1] * a_reg[R2*3+C2];
                q_reg[i*3+j]   <= a_reg[R1*3+C2] * a_reg[R2*3+C1];
                cof_reg[i*3+j] <= CW'(p_reg[i*3+j]) - CW'(q_reg[i*3+j]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < 3; j++)
        begin
            a0_s1_reg[j] <= a_reg[j];
            a0_s2_reg[j] <= a0_s1_reg[j];
        end
    end

    // Stage 3: first-row products split into low and high halves of the cofactor
    logic signed [CW-1:0] pl_reg [3];
    logic signed [CW-1:0] ph_reg [3];
    logic signed [CW-1:0] cof_s3_reg [9];
    logic signed [CW-1:0] cof_s4_reg [9];

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < 3; j++)
        begin
            pl_reg[j] <= a0_s2_reg[j] * $signed({1'b0, cof_reg[j][W-1:0]});
            ph_reg[j] <= a0_s2_reg[j] * $signed(cof_reg[j][CW-1:W]);
        end
        for (int k = 0; k < 9; k++)
        begin
            cof_s3_reg[k] <= cof_reg[k];
            cof_s4_reg[k] <= cof_s3_reg[k];
        end
    end

    // Stage 4: determinant
    logic signed [DTW-1:0] det_next;
    logic signed [DTW-1:0] det_reg;

    always_comb
    begin
        det_next = '0;
        for (int j = 0; j < 3; j++)
        begin
            det_next = det_next + (DTW'(ph_reg[j]) << W) + DTW'(pl_reg[j]);
        end
    end

    always_ff @(posedge clk)
    begin
        det_reg <= det_next;
    end

    // Stage 5: magnitudes, signs and the singular test
    logic signed [DTW-1:0] det_abs_next;
    logic [CMW-1:0]        cabs_next [9];
    logic signed [CW-1:0]  cneg;
    logic                  dneg_reg;
    logic [MAGW-1:0]       dabs_reg;
    logic                  sing_reg;
    logic [CMW-1:0]        cabs_reg [9];
    logic [8:0]            csgn_reg;

    always_comb
    begin
        cneg = '0;
        det_abs_next = det_reg[DTW-1] ? -det_reg : det_reg;
        for (int k = 0; k < 9; k++)
        begin
            cneg = -cof_s4_reg[k];
            cabs_next[k] = cof_s4_reg[k][CW-1] ? cneg[CMW-1:0] : cof_s4_reg[k][CMW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        dneg_reg <= det_reg[DTW-1];
        dabs_reg <= det_abs_next[MAGW-1:0];
        sing_reg <= SCW'(det_abs_next[MAGW-1:0]) <= (SCW'(thr_reg) << (2 * FRAC_BITS));
        for (int k = 0; k < 9; k++)
        begin
            cabs_reg[k] <= cabs_next[k];
            csgn_reg[k] <= cof_s4_reg[k][CW-1];
        end
    end

    // Stage 6: round and clamp the determinant, form dividend and divisor
    logic [MAGW:0]       dr_sum;
    logic [DCW-1:0]      dround;
    logic [DCW-1:0]      dlim;
    logic                dovf_next;
    logic [W-1:0]        dmag;
    logic [W-1:0]        dval_next;
    logic [NW-1:0]       num_reg [9];
    logic [DVW-1:0]      den_reg;
    logic [TAG_W-1:0]    tag_reg;

    always_comb
    begin
        dr_sum    = (MAGW+1)'(dabs_reg) + ((MAGW+1)'(1) << (2 * FRAC_BITS - 1));
        dround    = DCW'(dr_sum[MAGW:2*FRAC_BITS]);
        dlim      = (DCW'(1) << (W - 1)) - DCW'(!dneg_reg);
        dovf_next = dround > dlim;
        dmag      = dovf_next ? dlim[W-1:0] : dround[W-1:0];
        dval_next = dneg_reg ? -dmag : dmag;
    end

    always_ff @(posedge clk)
    begin
        den_reg <= DVW'(dabs_reg) << 1;
        tag_reg <= {sing_reg, dval_next, dovf_next, csgn_reg ^ {9{dneg_reg}}};
        for (int k = 0; k < 9; k++)
        begin
            num_reg[k] <= (NW'(cabs_reg[k]) << (2 * FRAC_BITS + 1)) + NW'(dabs_reg);
        end
    end

    // Division of every cofactor magnitude by the determinant
    logic             dv_valid;
    logic [QW-1:0]    dv_quot [9];
    logic             dv_ovf  [9];
    logic [TAG_W-1:0] dv_tag;

    m3inv_divider #(
        .LANES (9),
        .NW    (NW),
        .DVW   (DVW),
        .QW    (QW),
        .TAG_W (TAG_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (vld_reg[6]),
        .num       (num_reg),
        .den       (den_reg),
        .tag_in    (tag_reg),
        .out_valid (dv_valid),
        .quot      (dv_quot),
        .ovf       (dv_ovf),
        .tag_out   (dv_tag)
    );

    // Output: clamp, apply sign, transpose, pick identity on a singular matrix
    logic              t_sing;
    logic [W-1:0]      t_dval;
    logic              t_dovf;
    logic [8:0]        t_neg;
    logic [W-1:0]      elem [9];
    logic              ovf_next;
    logic [QW-1:0]     qlim;
    logic [QW-1:0]     qmag;
    logic              qsat;
    int                l;
    m3inv_pkg::out_word_t res_next;
    m3inv_pkg::out_word_t res_reg;
    logic                 done_reg;

    assign {t_sing, t_dval, t_dovf, t_neg} = dv_tag;

    always_comb
    begin
        ovf_next = t_dovf;
        qlim = '0;
        qmag = '0;
        qsat = 1'b0;
        l = 0;
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                l = j * 3 + i;
                qlim = (QW'(1) << (W - 1)) - QW'(!t_neg[l]);
                qsat = dv_ovf[l] || (dv_quot[l] > qlim);
                qmag = qsat ? qlim : dv_quot[l];
                if (t_sing)
                begin
                    elem[i*3+j] = (i == j) ? ONE_VAL : '0;
                    ovf_next = ovf_next | ((i == j) & ONE_OVF);
                end
                else
                begin
                    elem[i*3+j] = t_neg[l] ? -qmag[W-1:0] : qmag[W-1:0];
                    ovf_next = ovf_next | qsat;
                end
            end
        end
        res_next.b00        = elem[0];
        res_next.b01        = elem[1];
        res_next.b02        = elem[2];
        res_next.b10        = elem[3];
        res_next.b11        = elem[4];
        res_next.b12        = elem[5];
        res_next.b20        = elem[6];
        res_next.b21        = elem[7];
        res_next.b22        = elem[8];
        res_next.det_value  = t_dval;
        res_next.singular   = t_sing;
        res_next.overflowed = ovf_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= dv_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

// ===== rtl/m3inv_divider.sv =====
// Pipelined restoring divider, several lanes sharing one divisor, one bit per stage.
// Carries a sideband tag alongside; depends on nothing.
module m3inv_divider #(
    parameter int LANES = 9,
    parameter int NW    = 98,
    parameter int DVW   = 97,
    parameter int QW    = 33,
    parameter int TAG_W = 43
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [NW-1:0]    num [LANES],
    input  logic [DVW-1:0]   den,
    input  logic [TAG_W-1:0] tag_in,
    output logic             out_valid,
    output logic [QW-1:0]    quot [LANES],
    output logic             ovf [LANES],
    output logic [TAG_W-1:0] tag_out
);

    localparam int RW = (NW > DVW + QW) ? NW : DVW + QW;

    logic [RW-1:0]    rem_reg [QW+1][LANES];
    logic [QW-1:0]    q_reg   [QW+1][LANES];
    logic             ov_reg  [QW+1][LANES];
    logic [DVW-1:0]   den_reg [QW+1];
    logic [TAG_W-1:0] tag_reg [QW+1];
    logic [QW:0]      vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[QW-1:0], in_valid};
        end
    end

    // First stage: flag quotients that cannot fit in QW bits.
    always_ff @(posedge clk)
    begin
        den_reg[0] <= den;
        tag_reg[0] <= tag_in;
        for (int l = 0; l < LANES; l++)
        begin
            rem_reg[0][l] <= RW'(num[l]);
            q_reg[0][l]   <= '0;
            ov_reg[0][l]  <= RW'(num[l]) >= (RW'(den) << QW);
        end
    end

    for (genvar s = 1; s <= QW; s++)
    begin : g_stage
        localparam int B = QW - s;
        for (genvar l = 0; l < LANES; l++)
        begin : g_lane
            logic [RW-1:0] sub;
            logic          ge;
            assign sub = RW'(den_reg[s-1]) << B;
            assign ge  = rem_reg[s-1][l] >= sub;
            always_ff @(posedge clk)
            begin
                rem_reg[s][l] <= ge ? rem_reg[s-1][l] - sub : rem_reg[s-1][l];
                q_reg[s][l]   <= q_reg[s-1][l] | (QW'(ge) << B);
                ov_reg[s][l]  <= ov_reg[s-1][l];
            end
        end
        always_ff @(posedge clk)
        begin
            den_reg[s] <= den_reg[s-1];
            tag_reg[s] <= tag_reg[s-1];
        end
    end

    assign out_valid = vld_reg[QW];
    assign tag_out   = tag_reg[QW];
    for (genvar l = 0; l < LANES; l++)
    begin : g_out
        assign quot[l] = q_reg[QW][l];
        assign ovf[l]  = ov_reg[QW][l];
    end

endmodule

// ===== rtl/m3inv_checker.sv =====
// Port-level checks for the 3x3 matrix inverse core, bound to the top level.
// Depends on m3inv_pkg and matrix3x3_inverse_core_defines.svh.
`include "matrix3x3_inverse_core_defines.svh"

module m3inv_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          start,
    input logic                          busy,
    input m3inv_pkg::out_word_t          result,
    input logic                          done
);

    localparam int LAT = m3inv_pkg::LATENCY;

    // The pipeline never pushes back.
    `M3INV_ASSERT_IMP(a_never_busy, 1'b1, !busy)

    // Every accepted word comes out after the fixed latency.
    `M3INV_ASSERT_DELAY(a_latency, start && !busy, LAT, done)

    // No word appears without an acceptance the same distance back.
    `M3INV_ASSERT_IMP(a_no_spurious, done, $past(start && !busy, LAT))

    // A singular result carries the identity.
    `M3INV_ASSERT_IMP(a_singular_identity, done && result.singular,
        result.b01 == '0 && result.b02 == '0 && result.b10 == '0 &&
        result.b12 == '0 && result.b20 == '0 && result.b21 == '0 &&
        result.b00 == result.b11 && result.b11 == result.b22)

endmodule

bind matrix3x3_inverse_core m3inv_checker u_m3inv_checker (.*);
